/* sv/rmslef_pkg.sv */
`timescale 1ns / 1ps

package rmslef_pkg;

  localparam int SUM_W      = 48;
  localparam int DIVISOR_W  = 17;
  localparam int DIVIDEND_W = SUM_W + 1;
  localparam int QUO_W      = 50;            // dividend padded to an even width for the root
  localparam int ROOT_W     = QUO_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = 6;

  localparam int LEVEL_W    = 17;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_KEEP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_GAIN  = 2'd3;

  localparam logic [1:0] FMT_INT16 = 2'd0;
  localparam logic [1:0] FMT_INT32 = 2'd1;
  localparam logic [1:0] FMT_FLOAT = 2'd2;

  localparam logic [1:0]       FORMAT_RST      = FMT_INT16;
  localparam logic [CFG_W-1:0] SENSITIVITY_RST = 16'd18022;
  localparam logic [CFG_W-1:0] DECAY_KEEP_RST  = 16'd57147;
  localparam logic [CFG_W-1:0] DECAY_GAIN_RST  = 16'd5898;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

endpackage

/* sv/rmslef_in_if.sv */
`timescale 1ns / 1ps

interface rmslef_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_word;
  logic        last_in_buffer;

  modport source (output valid, output sample_word, output last_in_buffer, input ready);
  modport sink   (input valid, input sample_word, input last_in_buffer, output ready);
endinterface

/* sv/rmslef_out_if.sv */
`timescale 1ns / 1ps

interface rmslef_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] rms_level;
  logic [16:0] smooth_level;

  modport source (output valid, output rms_level, output smooth_level, input ready);
  modport sink   (input valid, input rms_level, input smooth_level, output ready);
endinterface

/* sv/rmslef_mul.sv */
`timescale 1ns / 1ps

module rmslef_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

/* sv/rmslef_root.sv */
`timescale 1ns / 1ps

// Shift-subtract unit: restoring divide one bit a cycle, then the square
// root of the quotient two bits a cycle, on the same subtractor.
module rmslef_root (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rmslef_pkg::root_req_t  req,
  output rmslef_pkg::root_rsp_t  rsp
);

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT, R_DONE} rstate_t;

  rstate_t                         state_r, state_nxt;
  logic [rmslef_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [rmslef_pkg::QUO_W-1:0]    q_r, q_nxt;
  logic [rmslef_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [rmslef_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [rmslef_pkg::DIVISOR_W-1:0] dvs_r, dvs_nxt;

  logic [rmslef_pkg::REM_W-1:0]    rem_sh, opnd;
  logic [rmslef_pkg::REM_W:0]      diff;
  logic                            ge;
  logic                            div_mode;

  assign div_mode = (state_r == R_DIV);
  assign rem_sh   = div_mode ? {rem_r[rmslef_pkg::REM_W-2:0], q_r[rmslef_pkg::QUO_W-1]}
                             : {rem_r[rmslef_pkg::REM_W-3:0],
                                q_r[rmslef_pkg::QUO_W-1:rmslef_pkg::QUO_W-2]};
  assign opnd     = div_mode ? rmslef_pkg::REM_W'(dvs_r) : {root_r, 2'b01};
  assign diff     = {1'b0, rem_sh} - {1'b0, opnd};
  assign ge       = ~diff[rmslef_pkg::REM_W];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    dvs_nxt   = dvs_r;
    case (state_r)
      R_IDLE: begin
        if (req.start) begin
          q_nxt     = rmslef_pkg::QUO_W'(req.dividend);
          dvs_nxt   = req.divisor;
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = R_DIV;
        end
      end
      R_DIV: begin
        rem_nxt  = ge ? diff[rmslef_pkg::REM_W-1:0] : rem_sh;
        q_nxt    = {q_r[rmslef_pkg::QUO_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == rmslef_pkg::STEP_W'(rmslef_pkg::DIV_STEPS - 1)) begin
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = R_SQRT;
        end
      end
      R_SQRT: begin
        rem_nxt  = ge ? diff[rmslef_pkg::REM_W-1:0] : rem_sh;
        q_nxt    = {q_r[rmslef_pkg::QUO_W-3:0], 2'b00};
        root_nxt = {root_r[rmslef_pkg::ROOT_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == rmslef_pkg::STEP_W'(rmslef_pkg::ROOT_STEPS - 1)) begin
          state_nxt = R_DONE;
        end
      end
      R_DONE: begin
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = (state_r == R_DONE);
  assign rsp.root = root_r;

endmodule

/* sv/rms_level_envelope_follower.sv */
`timescale 1ns / 1ps
// Plain sample: after accept, passes through S_SQ and S_ACC (square, accumulate) before ready again.
// Last sample of a buffer: also runs the shift-subtract unit (50 divide steps, 25 root steps,
// a done state) and up to four multiplier passes; a rising level skips the decay multiplies.
// Results wait in an output register; a last sample stalls only if it is full.
// rst_n is synchronous: clears sum, count, envelope, output valid, registers to defaults.
module rms_level_envelope_follower #(
  parameter int MAX_BUFFER_SAMPLES = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rmslef_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rmslef_pkg::CFG_W-1:0]        cfg_wdata,
  rmslef_in_if.sink                           in_ch,
  rmslef_out_if.source                        out_ch
);

  localparam int CNT_W = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam int LW    = rmslef_pkg::LEVEL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACC, S_RSTART, S_ROOT, S_TMUL, S_TGT, S_KMUL, S_GMUL, S_ENV, S_OUT
  } state_t;

  function automatic logic [31:0] float_mag(input logic [31:0] w);
    logic [7:0]  e;
    logic [7:0]  rsh;
    logic [31:0] m;
    logic [31:0] r;
    e   = w[30:23];
    m   = {8'h00, 1'b1, w[22:0]};
    rsh = 8'd119 - e;
    if (e == 8'hFF && w[22:0] != 23'h0) begin
      r = '0;
    end else if (e >= 8'd127) begin
      r = w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (e == 8'h00) begin
      r = '0;
    end else if (e >= 8'd119) begin
      r = m << (e - 8'd119);
    end else if (rsh >= 8'd32) begin
      r = '0;
    end else begin
      r = m >> rsh;
    end
    return r;
  endfunction

  state_t                            state_r, state_nxt;
  logic [1:0]                        fmt_r, fmt_nxt;
  logic [rmslef_pkg::CFG_W-1:0]      sens_r, sens_nxt;
  logic [rmslef_pkg::CFG_W-1:0]      keep_r, keep_nxt;
  logic [rmslef_pkg::CFG_W-1:0]      gain_r, gain_nxt;
  logic [rmslef_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [LW-1:0]                     env_r, env_nxt;
  logic [31:0]                       mag_r, mag_nxt;
  logic                              last_r, last_nxt;
  logic                              skip_r, skip_nxt;
  logic [LW-1:0]                     rms_r, rms_nxt;
  logic [LW-1:0]                     tgt_r, tgt_nxt;
  logic [33:0]                       kp_r, kp_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [LW-1:0]                     out_rms_r, out_rms_nxt;
  logic [LW-1:0]                     out_env_r, out_env_nxt;

  logic [31:0]                       mul_a, mul_b;
  logic [63:0]                       prod;
  logic [31:0]                       mag_in;
  logic [15:0]                       s16;
  logic [34:0]                       blend;
  logic [18:0]                       blend_q;
  rmslef_pkg::root_req_t             rreq;
  rmslef_pkg::root_rsp_t             rrsp;
  logic                              in_acc;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.rms_level    = out_rms_r;
  assign out_ch.smooth_level = out_env_r;

  assign s16 = in_ch.sample_word[15] ? (~in_ch.sample_word[15:0] + 16'd1)
                                     : in_ch.sample_word[15:0];
  always_comb begin
    case (fmt_r)
      rmslef_pkg::FMT_INT16: mag_in = {s16, 16'h0000};
      rmslef_pkg::FMT_INT32: mag_in = in_ch.sample_word[31] ? (~in_ch.sample_word + 32'd1)
                                                            : in_ch.sample_word;
      rmslef_pkg::FMT_FLOAT: mag_in = float_mag(in_ch.sample_word);
      default:               mag_in = '0;
    endcase
  end

  always_comb begin
    case (state_r)
      S_SQ:    begin mul_a = mag_r;       mul_b = mag_r;       end
      S_TMUL:  begin mul_a = 32'(rms_r);  mul_b = 32'(sens_r); end
      S_KMUL:  begin mul_a = 32'(env_r);  mul_b = 32'(keep_r); end
      S_GMUL:  begin mul_a = 32'(tgt_r);  mul_b = 32'(gain_r); end
      default: begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  rmslef_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  assign rreq.start    = (state_r == S_RSTART);
  assign rreq.dividend = {sum_r, 1'b0};
  assign rreq.divisor  = rmslef_pkg::DIVISOR_W'(count_r);

  rmslef_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .rsp   (rrsp)
  );

  assign blend   = {1'b0, kp_r} + {1'b0, prod[33:0]};
  assign blend_q = blend[34:16];

  always_comb begin
    state_nxt     = state_r;
    fmt_nxt       = fmt_r;
    sens_nxt      = sens_r;
    keep_nxt      = keep_r;
    gain_nxt      = gain_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    env_nxt       = env_r;
    mag_nxt       = mag_r;
    last_nxt      = last_r;
    skip_nxt      = skip_r;
    rms_nxt       = rms_r;
    tgt_nxt       = tgt_r;
    kp_nxt        = kp_r;
    out_valid_nxt = out_valid_r;
    out_rms_nxt   = out_rms_r;
    out_env_nxt   = out_env_r;

    if (cfg_we) begin
      case (cfg_index)
        rmslef_pkg::REG_FORMAT:      fmt_nxt  = cfg_wdata[1:0];
        rmslef_pkg::REG_SENSITIVITY: sens_nxt = cfg_wdata;
        rmslef_pkg::REG_DECAY_KEEP:  keep_nxt = cfg_wdata;
        rmslef_pkg::REG_DECAY_GAIN:  gain_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mag_nxt   = mag_in;
          last_nxt  = in_ch.last_in_buffer;
          skip_nxt  = (count_r == CNT_W'(MAX_BUFFER_SAMPLES));
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!skip_r) begin
          sum_nxt   = sum_r + rmslef_pkg::SUM_W'(prod[63:31]);
          count_nxt = count_r + 1'b1;
        end
        state_nxt = last_r ? S_RSTART : S_IDLE;
      end
      S_RSTART: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (rrsp.done) begin
          if (count_r == '0) begin
            rms_nxt = '0;
          end else if (rrsp.root > rmslef_pkg::ROOT_W'(rmslef_pkg::LEVEL_ONE)) begin
            rms_nxt = rmslef_pkg::LEVEL_ONE;
          end else begin
            rms_nxt = rrsp.root[LW-1:0];
          end
          state_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        state_nxt = S_TGT;
      end
      S_TGT: begin
        // sensitivity is Q3.13
        if (prod[32:13] > 20'(rmslef_pkg::LEVEL_ONE)) begin
          tgt_nxt = rmslef_pkg::LEVEL_ONE;
        end else begin
          tgt_nxt = prod[29:13];
        end
        if (tgt_nxt > env_r) begin
          env_nxt   = tgt_nxt;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_KMUL;
        end
      end
      S_KMUL: begin
        state_nxt = S_GMUL;
      end
      S_GMUL: begin
        kp_nxt    = prod[33:0];
        state_nxt = S_ENV;
      end
      S_ENV: begin
        env_nxt   = (blend_q > 19'(rmslef_pkg::LEVEL_ONE)) ? rmslef_pkg::LEVEL_ONE
                                                           : blend_q[LW-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_rms_nxt   = rms_r;
          out_env_nxt   = env_r;
          sum_nxt       = '0;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fmt_r       <= rmslef_pkg::FORMAT_RST;
      sens_r      <= rmslef_pkg::SENSITIVITY_RST;
      keep_r      <= rmslef_pkg::DECAY_KEEP_RST;
      gain_r      <= rmslef_pkg::DECAY_GAIN_RST;
      sum_r       <= '0;
      count_r     <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fmt_r       <= fmt_nxt;
      sens_r      <= sens_nxt;
      keep_r      <= keep_nxt;
      gain_r      <= gain_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      env_r       <= env_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r     <= mag_nxt;
    last_r    <= last_nxt;
    skip_r    <= skip_nxt;
    rms_r     <= rms_nxt;
    tgt_r     <= tgt_nxt;
    kp_r      <= kp_nxt;
    out_rms_r <= out_rms_nxt;
    out_env_r <= out_env_nxt;
  end

endmodule

/* sv/rmslef_chk.sv */
`timescale 1ns / 1ps

module rmslef_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] rms_level,
  input logic [16:0] smooth_level
);

  // a word out is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rms_level) && $stable(smooth_level))
    else $error("result word dropped or changed while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rms_level <= 17'h10000) && (smooth_level <= 17'h10000))
    else $error("level above full scale");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is still in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word with no work behind it");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind rms_level_envelope_follower rmslef_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .rms_level    (out_ch.rms_level),
  .smooth_level (out_ch.smooth_level)
);
